// ----- design/assert_macros.svh -----
// assertion macros for the conic orbit position block
// expects i_clk and i_rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define COP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define COP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define COP_ASSERT_IMP(lbl, ante, cons, msg)
`define COP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- design/cop_pkg.sv -----
// shared types, constants and arctangent table for the conic orbit position block
// no dependencies
`default_nettype none
package cop_pkg;
    localparam int CORDIC_STAGES = 20;
    localparam int PHASE_BITS    = 48;
    localparam int CW = 34;   // cordic x/y width
    localparam int ZW = 33;   // cordic angle residual width
    localparam int TW = 35;   // mapped sine/cosine width
    localparam int DW = 34;   // divisor and remainder width
    localparam int QB = 31;   // quotient bits
    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

    localparam logic [1:0] REG_EPOCH = 2'd0;
    localparam logic [1:0] REG_RATE  = 2'd1;
    localparam logic [1:0] REG_AXIS  = 2'd2;
    localparam logic [1:0] REG_ECC   = 2'd3;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [1:0]           quad;
    } t_cord;

    typedef struct packed {
        logic signed [TW-1:0] c;
        logic signed [TW-1:0] s;
        logic                 sat;
    } t_side;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [DW-1:0] dvs;
        logic [QB-1:0] numlo;
        logic [QB-1:0] quo;
        t_side         side;
    } t_div;

    // atan(2^-k) in units of 2^-32 turns
    function automatic logic signed [ZW-1:0] atan_turns(input logic [4:0] k);
        logic signed [ZW-1:0] v;
        case (k)
            5'd0:  v = ZW'(536870912);
            5'd1:  v = ZW'(316933406);
            5'd2:  v = ZW'(167458907);
            5'd3:  v = ZW'(85004756);
            5'd4:  v = ZW'(42667331);
            5'd5:  v = ZW'(21354465);
            5'd6:  v = ZW'(10679838);
            5'd7:  v = ZW'(5340245);
            5'd8:  v = ZW'(2670163);
            5'd9:  v = ZW'(1335087);
            5'd10: v = ZW'(667544);
            5'd11: v = ZW'(333772);
            5'd12: v = ZW'(166886);
            5'd13: v = ZW'(83443);
            5'd14: v = ZW'(41722);
            5'd15: v = ZW'(20861);
            5'd16: v = ZW'(10430);
            5'd17: v = ZW'(5215);
            5'd18: v = ZW'(2608);
            5'd19: v = ZW'(1304);
            5'd20: v = ZW'(652);
            5'd21: v = ZW'(326);
            5'd22: v = ZW'(163);
            5'd23: v = ZW'(81);
            5'd24: v = ZW'(41);
            5'd25: v = ZW'(20);
            5'd26: v = ZW'(10);
            5'd27: v = ZW'(5);
            5'd28: v = ZW'(3);
            5'd29: v = ZW'(1);
            5'd30: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ----- design/conic_orbit_position_top.sv -----
// conic orbit position: time in, in-plane x/z position out
// one beat per cycle while the output register is free
// the chain is one stall domain: every stage moves when the output register is free
// rate set by the registered cordic and divider cells; no beat is taken while stalled
// synchronous active-low reset clears valid bits and restores register defaults
// depends on cop_pkg, cop_cordic_cell, cop_div_cell, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module conic_orbit_position_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // time beats in
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_time_seconds,
    // position beats out
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_z,
    output logic        o_saturated
);
    import cop_pkg::*;

    // configuration registers
    logic [31:0] r_epoch;
    logic [31:0] r_rate;
    logic [23:0] r_axis;
    logic [15:0] r_ecc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch <= 32'd0;
            r_rate  <= 32'd1523800000;
            r_axis  <= 24'd720896;
            r_ecc   <= 16'd53620;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_EPOCH: r_epoch <= i_cfg_data;
                REG_RATE:  r_rate  <= i_cfg_data;
                REG_AXIS:  r_axis  <= i_cfg_data[23:0];
                REG_ECC:   r_ecc   <= i_cfg_data[15:0];
                default:   ;
            endcase
        end
    end

    // numerator a*(1-e^2), Q48, registered through r_esq and then r_num after a write
    logic [31:0] r_esq;
    logic [56:0] r_num;
    always_ff @(posedge i_clk) begin
        r_esq <= 32'(r_ecc) * 32'(r_ecc);
        r_num <= 57'(r_axis) * 57'(33'h1_0000_0000 - {1'b0, r_esq});
    end

    // one stall enable for the whole chain
    logic r_out_valid;
    logic en;
    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;

    // front: time difference, then phase product
    logic        r_v1, r_v2;
    logic [31:0] r_dt;
    logic [31:0] r_ang;
    logic [63:0] prod_phase;
    assign prod_phase = 64'(r_rate) * 64'(r_dt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        if (en) begin
            r_dt  <= i_time_seconds - r_epoch;
            r_ang <= prod_phase[PHASE_BITS-1 -: 32];
        end
    end

    // cordic chain: quadrant rides along, residual rotated
    t_cord cord [CORDIC_STAGES+1];
    logic  cv   [CORDIC_STAGES+1];

    assign cord[0] = {CORDIC_GAIN, CW'(0), {3'b000, r_ang[29:0]}, r_ang[31:30]};
    assign cv[0]   = r_v2;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        cop_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (cv[g]),
            .i_shift (5'(g)),
            .i_cord  (cord[g]),
            .o_valid (cv[g+1]),
            .o_cord  (cord[g+1])
        );
    end

    // quadrant fold and e*cos
    t_cord                 cl;
    logic signed [TW-1:0]  map_c, map_s;
    logic                  r_v3;
    logic signed [TW-1:0]  r_c, r_s;
    logic signed [51:0]    r_ec;
    assign cl = cord[CORDIC_STAGES];

    always_comb begin
        case (cl.quad)
            2'd0: begin
                map_c = TW'(cl.x);
                map_s = TW'(cl.y);
            end
            2'd1: begin
                map_c = -TW'(cl.y);
                map_s = TW'(cl.x);
            end
            2'd2: begin
                map_c = -TW'(cl.x);
                map_s = -TW'(cl.y);
            end
            default: begin
                map_c = TW'(cl.y);
                map_s = -TW'(cl.x);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= cv[CORDIC_STAGES];
        end
        if (en) begin
            r_c  <= map_c;
            r_s  <= map_s;
            r_ec <= $signed({1'b0, r_ecc}) * 52'(map_c);
        end
    end

    // denominator 1 + e*cos, forced positive; early range check of the quotient
    logic signed [36:0] den;
    logic [DW-1:0]      dvs;
    t_div               div [QB+1];
    logic               dv  [QB+1];
    logic               r_v4;
    t_div               r_div0;

    always_comb begin
        den = 37'sh4000_0000 + 37'(r_ec >>> 16);
        if (den < 37'sd1) begin
            den = 37'sd1;
        end
        dvs = {den[31:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= r_v3;
        end
        if (en) begin
            r_div0.rem      <= DW'(r_num[56:QB]);
            r_div0.dvs      <= dvs;
            r_div0.numlo    <= r_num[QB-1:0];
            r_div0.quo      <= '0;
            r_div0.side.c   <= r_c;
            r_div0.side.s   <= r_s;
            // quotient would need more than 31 bits
            r_div0.side.sat <= ({8'd0, r_num[56:QB]} >= dvs);
        end
    end

    assign div[0] = r_div0;
    assign dv[0]  = r_v4;

    for (genvar g = 0; g < QB; g++) begin : g_div
        cop_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv[g]),
            .i_div   (div[g]),
            .o_valid (dv[g+1]),
            .o_div   (div[g+1])
        );
    end

    // radius times sine and cosine
    t_div               dl;
    logic [QB-1:0]      rad;
    logic               r_v5;
    logic               r_sat5;
    logic signed [66:0] r_px, r_pc;
    assign dl  = div[QB];
    assign rad = dl.side.sat ? {QB{1'b1}} : dl.quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v5 <= dv[QB];
        end
        if (en) begin
            r_sat5 <= dl.side.sat;
            r_px   <= $signed({1'b0, rad}) * 67'(dl.side.s);
            r_pc   <= $signed({1'b0, rad}) * 67'(dl.side.c);
        end
    end

    // scale back to Q16 and clamp into 32 bits
    logic signed [36:0] xs;
    logic signed [37:0] zs;
    logic signed [31:0] xo, zo;
    logic               xsat, zsat;

    always_comb begin
        xs = 37'(r_px >>> 30);
        zs = -38'(r_pc >>> 30);
        xsat = 1'b0;
        zsat = 1'b0;
        xo = xs[31:0];
        zo = zs[31:0];
        if (xs > 37'sh7FFF_FFFF) begin
            xo = 32'sh7FFF_FFFF;
            xsat = 1'b1;
        end else if (xs < -37'sh8000_0000) begin
            xo = 32'sh8000_0000;
            xsat = 1'b1;
        end
        if (zs > 38'sh7FFF_FFFF) begin
            zo = 32'sh7FFF_FFFF;
            zsat = 1'b1;
        end else if (zs < -38'sh8000_0000) begin
            zo = 32'sh8000_0000;
            zsat = 1'b1;
        end
    end

    // output register
    logic               r_sat;
    logic signed [31:0] r_x, r_z;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_v5;
        end
        if (en) begin
            r_x   <= xo;
            r_z   <= zo;
            r_sat <= r_sat5 | xsat | zsat;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pos_x     = r_x;
    assign o_pos_z     = r_z;
    assign o_saturated = r_sat;

    // a held output beat freezes the whole chain
    `COP_ASSERT_IMP(a_stall_blocks_input, r_out_valid && !i_ready, !o_ready, "stall leaked")
    // divisor entering the divider is never zero
    `COP_ASSERT_IMP(a_divisor_nonzero, r_v4, r_div0.dvs != '0, "zero divisor")
    // last product stage always lands in the output register
    `COP_ASSERT_NXT(a_last_stage_moves, r_v5 && en, r_out_valid, "beat lost at output")
endmodule
`default_nettype wire

// ----- design/cop_cordic_cell.sv -----
// one rotation stage of the cordic chain
// depends on cop_pkg
`default_nettype none
module cop_cordic_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [4:0]     i_shift,
    input  cop_pkg::t_cord i_cord,
    output logic           o_valid,
    output cop_pkg::t_cord o_cord
);
    import cop_pkg::*;

    logic          r_valid;
    t_cord         r_cord;
    t_cord         n_cord;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] at;

    always_comb begin
        dx = i_cord.y >>> i_shift;
        dy = i_cord.x >>> i_shift;
        at = atan_turns(i_shift);
        n_cord = i_cord;
        if (!i_cord.z[ZW-1]) begin
            n_cord.x = i_cord.x - dx;
            n_cord.y = i_cord.y + dy;
            n_cord.z = i_cord.z - at;
        end else begin
            n_cord.x = i_cord.x + dx;
            n_cord.y = i_cord.y - dy;
            n_cord.z = i_cord.z + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_cord <= n_cord;
        end
    end

    assign o_valid = r_valid;
    assign o_cord  = r_cord;
endmodule
`default_nettype wire

// ----- design/cop_div_cell.sv -----
// one restoring division step: one quotient bit per cell
// depends on cop_pkg
`default_nettype none
module cop_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  cop_pkg::t_div i_div,
    output logic          o_valid,
    output cop_pkg::t_div o_div
);
    import cop_pkg::*;

    logic          r_valid;
    t_div          r_div;
    t_div          n_div;
    logic [DW:0]   trial;
    logic          ge;

    always_comb begin
        trial = {i_div.rem, i_div.numlo[QB-1]};
        ge    = (trial >= {1'b0, i_div.dvs});
        n_div = i_div;
        n_div.rem   = ge ? DW'(trial - {1'b0, i_div.dvs}) : DW'(trial);
        n_div.numlo = {i_div.numlo[QB-2:0], 1'b0};
        n_div.quo   = {i_div.quo[QB-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
endmodule
`default_nettype wire

// ----- verif/conic_orbit_position_top_test.sv -----
// testbench for conic_orbit_position_top: time beats in, predicted x/z position beats checked
// depends on cop_pkg and the conic_orbit_position_top rtl
`timescale 1ns / 100ps
`default_nettype none

// scoreboard: holds the register copy and the queue of predicted positions
class orbit_position_board;
    logic [31:0] epoch;
    logic [31:0] rate;
    logic [23:0] axis;
    logic [15:0] ecc;
    logic [64:0] pending[$];   // {x, z, sat}
    int          mismatches;
    int          checked;

    function new();
        restore_defaults();
        mismatches = 0;
        checked = 0;
    endfunction

    function void restore_defaults();
        epoch = 32'd0;
        rate  = 32'd1523800000;
        axis  = 24'd720896;
        ecc   = 16'd53620;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
        case (idx)
            cop_pkg::REG_EPOCH: epoch = data;
            cop_pkg::REG_RATE:  rate  = data;
            cop_pkg::REG_AXIS:  axis  = data[23:0];
            cop_pkg::REG_ECC:   ecc   = data[15:0];
            default: ;
        endcase
    endfunction

    // arctangent table for the rotation stages, 2^-32 turn units
    function longint arc_step(int k);
        longint tbl[32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
            81, 41, 20, 10, 5, 3, 1, 1, 0};
        return tbl[k];
    endfunction

    function longint clamp_word(longint v, ref bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // predicts one position beat from a time beat
    function void note_time(logic [31:0] t);
        logic [31:0]  dt;
        logic [63:0]  prod;
        logic [31:0]  ang;
        logic [1:0]   quad;
        longint       zr, cx, cy, dx, dy, c, s, den, r, xp, zp;
        logic [127:0] num, q;
        bit           sat;
        sat  = 0;
        dt   = t - epoch;
        prod = {32'd0, rate} * {32'd0, dt};
        ang  = prod[cop_pkg::PHASE_BITS-1 -: 32];
        quad = ang[31:30];
        zr   = longint'({34'd0, ang[29:0]});
        cx   = 652032874;
        cy   = 0;
        for (int i = 0; i < cop_pkg::CORDIC_STAGES; i++) begin
            dx = cy >>> (i % 32);
            dy = cx >>> (i % 32);
            if (zr >= 0) begin
                cx -= dx; cy += dy; zr -= arc_step(i % 32);
            end else begin
                cx += dx; cy -= dy; zr += arc_step(i % 32);
            end
        end
        case (quad)
            2'd0: begin c = cx;  s = cy;  end
            2'd1: begin c = -cy; s = cx;  end
            2'd2: begin c = -cx; s = -cy; end
            default: begin c = cy; s = -cx; end
        endcase
        num = 128'(axis) * ((128'd1 << 32) - 128'(ecc) * 128'(ecc));
        den = (64'sd1 <<< 30) + ((longint'(ecc) * c) >>> 16);
        if (den < 1) den = 1;
        q = num / (128'(den) * 4);
        if (q > 128'd2147483647) begin
            q = 128'd2147483647;
            sat = 1;
        end
        r  = longint'(q[63:0]);
        xp = clamp_word((r * s) >>> 30, sat);
        zp = clamp_word(-((r * c) >>> 30), sat);
        pending.push_back({xp[31:0], zp[31:0], sat});
    endfunction

    task check_position(logic [31:0] x, logic [31:0] z, logic sat);
        logic [64:0] want;
        if (pending.size() == 0) begin
            report($sformatf("unexpected position beat x=%h z=%h", x, z));
            return;
        end
        want = pending.pop_front();
        checked++;
        if (want[64:33] !== x) report($sformatf("pos_x %h want %h", x, want[64:33]));
        if (want[32:1] !== z) report($sformatf("pos_z %h want %h", z, want[32:1]));
        if (want[0] !== sat) report($sformatf("saturated %b want %b", sat, want[0]));
    endtask

    task report(string msg);
        mismatches++;
        if (mismatches <= 40) $display("mismatch: %s", msg);
    endtask
endclass

module conic_orbit_position_top_test;
    import cop_pkg::*;

    localparam int LATENCY = CORDIC_STAGES + QB + 6;
    localparam int IDLE_LIMIT = 20000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_idx = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [31:0] time_s = '0;
    logic        out_valid;
    logic        out_ready = 0;
    logic signed [31:0] pos_x, pos_z;
    logic        sat_flag;

    orbit_position_board board = new();

    // idle percentages for sender and receiver, changed per phase
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 0;       // long receiver hold-off request
    bit stim_done = 0;
    int idle_cycles = 0;
    int sent = 0;

    always #2 clk = ~clk;

    conic_orbit_position_top u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready), .i_time_seconds(time_s),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_pos_x(pos_x), .o_pos_z(pos_z), .o_saturated(sat_flag)
    );

    // receiver side: random stalls, plus one long hold-off requested through hold_off
    always @(posedge clk) begin
        if (out_valid && out_ready && rst_n)
            board.check_position(pos_x, pos_z, sat_flag);
        if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        hold_off = 0;
        wait (sent >= 700);
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
    end

    // watchdog: cycles without any beat accepted on either side
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired, %0d beats outstanding", board.pending.size());
            $display("[conic_orbit_position_top] ERROR");
            $finish;
        end
    end

    // offers one time beat and waits for its acceptance; valid stays up for the next beat
    task automatic send_time(logic [31:0] t);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        in_valid <= 1'b1;
        time_s   <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_time(t);
        sent++;
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        board.write_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // lets the pipeline drain before touching registers
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic random_config();
        case ($urandom_range(3))
            0: write_cfg(REG_EPOCH, $urandom());
            1: write_cfg(REG_RATE, $urandom_range(1) ? $urandom() : $urandom_range(2000));
            2: write_cfg(REG_AXIS, $urandom_range(1) ? $urandom_range(24'hFFFFFF)
                                                     : $urandom_range(2000000));
            default: write_cfg(REG_ECC, $urandom_range(1) ? $urandom_range(16'hFFFF)
                                                          : 16'hFFFF - $urandom_range(50));
        endcase
    endtask

    task automatic random_block(int n);
        logic [31:0] t;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: t = board.epoch + $urandom_range(5000);
                1: t = board.epoch - $urandom_range(5000);
                default: t = $urandom();
            endcase
            send_time(t);
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: time extremes, epoch passage, wrap before epoch
        send_time(32'd0);
        send_time(32'hFFFF_FFFF);
        send_time(32'd1);
        send_time(32'h8000_0000);
        send_time(32'h5555_5555);
        send_time(32'hAAAA_AAAA);
        drain();
        // zero eccentricity, circular orbit at full axis
        write_cfg(REG_ECC, 32'd0);
        write_cfg(REG_AXIS, 32'hFFFFFF);
        write_cfg(REG_RATE, 32'hFFFF_FFFF);
        write_cfg(REG_EPOCH, 32'h1234_5678);
        send_time(32'h1234_5678);
        send_time(32'h1234_5677);
        send_time(32'h0);
        send_time(32'hFFFF_FFFF);
        drain();
        // near-parabolic eccentricity; every time lands on phase zero, at periapsis
        write_cfg(REG_ECC, 32'hFFFF);
        write_cfg(REG_RATE, 32'h4000_0000);
        write_cfg(REG_EPOCH, 32'd0);
        for (int k = 0; k < 8; k++) send_time(32'(k * 65536 * 4));
        drain();
        write_cfg(REG_AXIS, 32'd0);
        write_cfg(REG_RATE, 32'd0);
        send_time(32'hDEAD_BEEF);
        send_time(32'd7);
        drain();

        // random phases with varied idling
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            repeat (2) random_config();
            if (ph == 4) board.restore_defaults();
            if (ph == 4) begin
                write_cfg(REG_EPOCH, 32'd0);
                write_cfg(REG_RATE, 32'd1523800000);
                write_cfg(REG_AXIS, 32'd720896);
                write_cfg(REG_ECC, 32'd53620);
            end
            random_block(128);
            drain();
        end
        stim_done = 1;

        $display("covered %0d time beats, %0d positions checked over several register sets",
                 sent, board.checked);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("[conic_orbit_position_top] OK");
        else
            $display("[conic_orbit_position_top] ERROR");
        $finish;
    end
endmodule

// ----- conic_orbit_position_top.f -----
+incdir+design
design/cop_pkg.sv
design/cop_cordic_cell.sv
design/cop_div_cell.sv
design/conic_orbit_position_top.sv
verif/conic_orbit_position_top_test.sv
